>>> rtl/dcvs_pkg.sv
// Shared types, constants and helper functions of the vertical scaler line-count block.
// Used by the serial divider, the top level and the port checker. No dependencies.
package dcvs_pkg;

  localparam int unsigned HeightW   = 11;
  localparam int unsigned RegW      = 9;
  localparam int unsigned DividendW = 19;
  localparam int unsigned DivisorW  = 11;
  localparam int unsigned DivSteps  = 19;
  localparam int unsigned StepCntW  = 5;
  localparam int unsigned SumW      = 20;

  localparam logic [SumW-1:0]    MaxLines = 20'd1024;
  localparam logic [RegW-1:0]    RegUnit  = 9'h100;
  localparam logic [RegW-1:0]    RegFull  = 9'h1FF;
  localparam logic [HeightW-1:0] TgtLimit = 11'd2047;

  typedef struct packed {
    logic               func;
    logic [HeightW-1:0] source_height;
    logic [HeightW-1:0] dest_height;
    logic [RegW-1:0]    scale_code;
  } dcvs_req_t;

  typedef struct packed {
    logic [HeightW-1:0] line_count;
    logic [RegW-1:0]    scale_register;
    logic [HeightW-1:0] ratio_num;
    logic [HeightW-1:0] ratio_den;
  } dcvs_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PACK_GO,
    ST_PACK_WAIT,
    ST_CNT_GO,
    ST_CNT_WAIT,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_EVAL,
    ST_OUT
  } dcvs_state_e;

  typedef enum logic {
    PH_DOWN,
    PH_UP
  } dcvs_phase_e;

  // Drop trailing zero bits of a nonzero byte.
  function automatic logic [7:0] strip_zeros(input logic [7:0] r);
    logic [7:0] s;
    s = r;
    for (int i = 0; i < 7; i++) begin
      if (s[0] == 1'b0) begin
        s = s >> 1;
      end
    end
    return s;
  endfunction

  // Cap a raw line count at the frame limit.
  function automatic logic [HeightW-1:0] cap_lines(input logic [SumW-1:0] n);
    logic [SumW-1:0] c;
    c = (n > MaxLines) ? MaxLines : n;
    return c[HeightW-1:0];
  endfunction

  // Cut a scale quotient to the register width; a zero register becomes one.
  function automatic logic [RegW-1:0] pack_fix(input logic [DividendW-1:0] q);
    logic [RegW-1:0] r;
    r = q[RegW-1:0];
    if (r == '0) begin
      r = {{(RegW-1){1'b0}}, 1'b1};
    end
    return r;
  endfunction

endpackage

>>> rtl/dcvs_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on dcvs_pkg for operand widths and step count.
module dcvs_divider import dcvs_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [DividendW-1:0] dividend_i,
  input  logic [DivisorW-1:0]  divisor_i,
  output logic                 done_o,
  output logic [DividendW-1:0] quotient_o,
  output logic [DivisorW-1:0]  remainder_o
);

  logic                 run_q, run_d;
  logic                 done_q, done_d;
  logic [StepCntW-1:0]  step_q, step_d;
  logic [DividendW-1:0] quo_q, quo_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dsr_q, dsr_d;
  logic [DivisorW+1:0]  trial;
  logic                 neg;

  // Trial subtract of the divisor from the shifted partial remainder.
  assign trial = {1'b0, rem_q, quo_q[DividendW-1]} - {2'b00, dsr_q};
  assign neg   = trial[DivisorW+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = StepCntW'(DivSteps);
      quo_d  = dividend_i;
      rem_d  = '0;
      dsr_d  = divisor_i;
    end else if (run_q) begin
      rem_d  = neg ? {rem_q[DivisorW-2:0], quo_q[DividendW-1]} : trial[DivisorW-1:0];
      quo_d  = {quo_q[DividendW-2:0], ~neg};
      step_d = step_q - StepCntW'(1);
      if (step_q == StepCntW'(1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    step_q <= step_d;
    quo_q  <= quo_d;
    rem_q  <= rem_d;
    dsr_q  <= dsr_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

>>> rtl/display_copy_vertical_scaler_lines_core.sv
// Top level of the vertical scaler line-count block: sequencer and datapath registers.
// Depends on dcvs_pkg and dcvs_divider.
//
// A request is taken on a clock edge with start high and busy low; busy then stays high until
// the single result has been shown. The result is on res_o for exactly one cycle with
// res_valid_o high, and the receiver must take it then: there is no way to hold it off. All
// arithmetic goes through one serial divider that yields one quotient bit per cycle, so its
// 19-step runs set the time per request. Evaluating one line count takes one division, plus
// a second run for the divisibility check when the scale register lies between 0x81 and 0xFF.
// A line-count request (func 0) needs no division when the register or the source height is
// zero. A scale search (func 1) evaluates one candidate height per step, each with a packing
// division (none for a zero candidate), a count division and the optional check, and walks
// from the destination height down, then up, one line at a time; the number of candidates
// visited can reach about two thousand. A zero source or destination height in a search takes
// the unit-scale path and is counted like a func 0 request.
module display_copy_vertical_scaler_lines_core import dcvs_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  dcvs_req_t req_i,
  output logic      res_valid_o,
  output dcvs_res_t res_o
);

  dcvs_state_e state_q, state_d;

  // Request and working registers.
  logic [HeightW-1:0] h_q;
  logic [HeightW-1:0] xfb_q;
  logic               search_q;
  dcvs_phase_e        phase_q;
  logic [HeightW-1:0] tgt_q;
  logic [RegW-1:0]    reg_q;
  logic [HeightW-1:0] cnt_q;
  logic [SumW-1:0]    sum_q;
  logic [HeightW-1:0] num_q;
  logic [HeightW-1:0] den_q;

  // Best candidate so far during the upward walk.
  logic [HeightW-1:0] best_tgt_q;
  logic [RegW-1:0]    best_reg_q;
  logic [HeightW-1:0] best_cnt_q;

  dcvs_res_t res_q;

  // Divider hookup.
  logic                 div_start;
  logic [DividendW-1:0] div_dividend;
  logic [DivisorW-1:0]  div_divisor;
  logic                 div_done;
  logic [DividendW-1:0] div_quo;
  logic [DivisorW-1:0]  div_rem;

  logic               accept;
  logic               req_zero;
  logic               in_range;
  logic               go_down;
  logic               go_up;
  logic               walk_on;
  logic [SumW-1:0]    quo_inc;
  logic [HeightW-1:0] h_dec;

  assign accept   = start && !busy;
  assign req_zero = (req_i.source_height == '0) || (req_i.dest_height == '0);

  // Registers from 0x81 to 0xFF need the extra divisibility check.
  assign in_range = !reg_q[RegW-1] && reg_q[RegW-2] && (reg_q[RegW-3:0] != '0);

  // Walk decisions: step down while the count overshoots, then up while it falls short.
  assign go_down = (phase_q == PH_DOWN) && (cnt_q > xfb_q) && (tgt_q != '0);
  assign go_up   = !go_down && (cnt_q < xfb_q) && (tgt_q != TgtLimit);
  assign walk_on = search_q && (go_down || go_up);

  assign quo_inc = {1'b0, div_quo} + SumW'(1);
  assign h_dec   = h_q - HeightW'(1);

  dcvs_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = (req_i.func && !req_zero) ? ST_PACK_GO : ST_CNT_GO;
        end
      end
      ST_PACK_GO: begin
        state_d = (tgt_q == '0) ? ST_CNT_GO : ST_PACK_WAIT;
      end
      ST_PACK_WAIT: begin
        if (div_done) begin
          state_d = ST_CNT_GO;
        end
      end
      ST_CNT_GO: begin
        state_d = ((reg_q == '0) || (h_q == '0)) ? ST_EVAL : ST_CNT_WAIT;
      end
      ST_CNT_WAIT: begin
        if (div_done) begin
          state_d = in_range ? ST_MOD_GO : ST_EVAL;
        end
      end
      ST_MOD_GO: begin
        state_d = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        if (div_done) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        state_d = walk_on ? ST_PACK_GO : ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs: divider launch and operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state_q)
      ST_PACK_GO: begin
        // 256 * source height / candidate height.
        div_start    = (tgt_q != '0);
        div_dividend = {h_q, 8'h00};
        div_divisor  = tgt_q;
      end
      ST_CNT_GO: begin
        // (h - 1) * 256 / register.
        div_start    = (reg_q != '0) && (h_q != '0);
        div_dividend = {h_dec, 8'h00};
        div_divisor  = {2'b00, reg_q};
      end
      ST_MOD_GO: begin
        // h modulo the register with trailing zeros stripped.
        div_start    = 1'b1;
        div_dividend = {8'h00, h_q};
        div_divisor  = {3'b000, strip_zeros(reg_q[7:0])};
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  assign busy        = (state_q != ST_IDLE);
  assign res_valid_o = (state_q == ST_OUT);
  assign res_o       = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers, advanced by the sequencer state.
  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          h_q      <= req_i.source_height;
          xfb_q    <= req_i.dest_height;
          tgt_q    <= req_i.dest_height;
          phase_q  <= PH_DOWN;
          search_q <= req_i.func && !req_zero;
          if (!req_i.func) begin
            reg_q <= req_i.scale_code;
            num_q <= '0;
            den_q <= '0;
          end else begin
            // Unit scale; a search overwrites the register per candidate.
            reg_q <= RegUnit;
            num_q <= HeightW'(1);
            den_q <= HeightW'(1);
          end
        end
      end
      ST_PACK_GO: begin
        // Zero numerator packs to the all-ones register.
        if (tgt_q == '0) begin
          reg_q <= RegFull;
        end
      end
      ST_PACK_WAIT: begin
        if (div_done) begin
          reg_q <= pack_fix(div_quo);
        end
      end
      ST_CNT_GO: begin
        if (reg_q == '0) begin
          cnt_q <= h_q;
        end else if (h_q == '0) begin
          cnt_q <= '0;
        end
      end
      ST_CNT_WAIT: begin
        if (div_done) begin
          sum_q <= quo_inc;
          cnt_q <= cap_lines(quo_inc);
        end
      end
      ST_MOD_WAIT: begin
        // Exact division adds one line.
        if (div_done && (div_rem == '0)) begin
          cnt_q <= cap_lines(sum_q + SumW'(1));
        end
      end
      ST_EVAL: begin
        if (search_q) begin
          if (go_down) begin
            tgt_q <= tgt_q - HeightW'(1);
          end else begin
            phase_q <= PH_UP;
            if ((phase_q == PH_DOWN) || go_up) begin
              best_tgt_q <= tgt_q;
              best_reg_q <= reg_q;
              best_cnt_q <= cnt_q;
            end
            if (go_up) begin
              tgt_q <= tgt_q + HeightW'(1);
            end
          end
        end
        if (!walk_on) begin
          if (!search_q) begin
            res_q.line_count     <= cnt_q;
            res_q.scale_register <= reg_q;
            res_q.ratio_num      <= num_q;
            res_q.ratio_den      <= den_q;
          end else if (phase_q == PH_DOWN) begin
            // Walk ends right where it stands.
            res_q.line_count     <= cnt_q;
            res_q.scale_register <= reg_q;
            res_q.ratio_num      <= tgt_q;
            res_q.ratio_den      <= h_q;
          end else begin
            res_q.line_count     <= best_cnt_q;
            res_q.scale_register <= best_reg_q;
            res_q.ratio_num      <= best_tgt_q;
            res_q.ratio_den      <= h_q;
          end
        end
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

endmodule

>>> rtl/dcvs_checker.sv
// Port-level checker for the vertical scaler line-count block, bound to the top level.
// Depends on dcvs_pkg for the result type and register constants.
module dcvs_checker import dcvs_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start,
  input logic      busy,
  input logic      res_valid_o,
  input dcvs_res_t res_o
);

  // A taken request keeps the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("request taken but block not busy");

  // A result only shows while a request is in flight.
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> busy)
    else $error("result strobe while idle");

  // The strobe lasts one cycle and frees the block.
  a_res_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> (!res_valid_o && !busy))
    else $error("result strobe not followed by idle");

  // Line-count requests report no ratio.
  a_ratio_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.ratio_den == '0)) |-> (res_o.ratio_num == '0))
    else $error("ratio numerator set without denominator");

  // A zero numerator in a search packs to the all-ones register.
  a_num_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && (res_o.ratio_den != '0) && (res_o.ratio_num == '0))
      |-> (res_o.scale_register == RegFull))
    else $error("zero numerator with wrong register");

endmodule

bind display_copy_vertical_scaler_lines_core dcvs_checker u_dcvs_checker (.*);

>>> dv/testbench.sv
// Self-checking testbench for display_copy_vertical_scaler_lines_core: line-count and scale-search
// requests, each result checked field by field against an in-bench predictor.
// Depends on dcvs_pkg and the RTL of the scaler core only.
module testbench;
  import dcvs_pkg::*;

  // Function select codes of a request.
  localparam logic FuncLines  = 1'b0;
  localparam logic FuncSearch = 1'b1;

  localparam int unsigned LineCap    = 1024;
  localparam int unsigned ScaleOne   = 256;
  localparam int unsigned MaxHeight  = 1024;
  // Generous bound: the unreachable search walks every candidate from 1024 up to the target ceiling.
  localparam int unsigned CycleLimit = 4000000;
  localparam int unsigned DrainCycles = 200;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  dcvs_req_t req_i;
  logic      res_valid_o;
  dcvs_res_t res_o;

  dcvs_res_t   outcome_q[$];
  int          sender_idle_pct;
  int unsigned cycle_count;
  int unsigned n_line_reqs;
  int unsigned n_search_reqs;
  int unsigned n_checked;
  int unsigned n_errors;

  display_copy_vertical_scaler_lines_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Shift out trailing zero bits of a nonzero register value.
  function automatic int unsigned odd_part(input int unsigned r);
    int unsigned s;
    s = r;
    while (s[0] == 1'b0) s = s >> 1;
    return s;
  endfunction

  // Output lines for height h at register r; a zero register passes the height through.
  function automatic int unsigned line_total(input int unsigned h, input int unsigned r);
    int unsigned n;
    if (r == 0) return h;
    if (h == 0) return 0;
    n = (h - 1) * ScaleOne / r + 1;
    // Registers just below unit scale gain a line when their odd part divides the height.
    if (r > 'h80 && r < 'h100 && (h % odd_part(r)) == 0) n++;
    if (n > LineCap) n = LineCap;
    return n;
  endfunction

  // Pack the ratio num/den into the 9-bit reciprocal register.
  function automatic logic [RegW-1:0] pack_ratio(input int unsigned num, input int unsigned den);
    int unsigned q;
    if (num == 0) return RegFull;
    q = ScaleOne * den / num;
    if (q[RegW-1:0] == '0) return 9'd1;
    return q[RegW-1:0];
  endfunction

  // Compute the result a request must produce.
  function automatic dcvs_res_t scale_outcome(input dcvs_req_t r);
    dcvs_res_t   o;
    int unsigned h;
    int unsigned want;
    int unsigned tgt;
    int unsigned chosen;
    int unsigned got;
    o    = '0;
    h    = 32'(r.source_height);
    want = 32'(r.dest_height);
    if (r.func == FuncLines) begin
      o.scale_register = r.scale_code;
      o.line_count     = HeightW'(line_total(h, 32'(r.scale_code)));
    end else if (h == 0 || want == 0) begin
      // Unit scale for an empty source or destination.
      o.ratio_num      = 11'd1;
      o.ratio_den      = 11'd1;
      o.scale_register = pack_ratio(1, 1);
      o.line_count     = HeightW'(line_total(h, 32'(o.scale_register)));
    end else begin
      // Walk the target down until the count fits, then up until it is reached.
      tgt = want;
      got = line_total(h, pack_ratio(tgt, h));
      while (got > want && tgt > 0) begin
        tgt--;
        got = line_total(h, pack_ratio(tgt, h));
      end
      chosen = tgt;
      while (got < want && tgt < TgtLimit) begin
        chosen = tgt;
        tgt++;
        got = line_total(h, pack_ratio(tgt, h));
      end
      o.ratio_num      = chosen[HeightW-1:0];
      o.ratio_den      = h[HeightW-1:0];
      o.scale_register = pack_ratio(chosen, h);
      o.line_count     = HeightW'(line_total(h, 32'(o.scale_register)));
    end
    return o;
  endfunction

  // ---------------------------------------------------------------------------
  // Request driver and result checker
  // ---------------------------------------------------------------------------

  // Present one request at a clock edge and hold it until the core takes it.
  task automatic issue_request(input dcvs_req_t r);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    // Accepted at the first edge that sees busy low.
    while (busy) @(posedge clk_i);
    outcome_q.push_back(scale_outcome(r));
    if (r.func == FuncLines) n_line_reqs++;
    else n_search_reqs++;
    // Drop start for a while now and then; otherwise keep it high for the next request.
    if ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 70)) @(posedge clk_i);
    end
  endtask

  function automatic dcvs_req_t make_request(input logic f, input int unsigned h,
                                             input int unsigned d, input int unsigned c);
    dcvs_req_t r;
    r.func          = f;
    r.source_height = h[HeightW-1:0];
    r.dest_height   = d[HeightW-1:0];
    r.scale_code    = c[RegW-1:0];
    return r;
  endfunction

  // Compare every strobed result with the oldest prediction.
  always @(posedge clk_i) begin
    dcvs_res_t want_r;
    if (rst_ni && res_valid_o) begin
      if (outcome_q.size() == 0) begin
        $display("%0t: result with nothing pending: %p", $time, res_o);
        n_errors++;
      end else begin
        want_r = outcome_q.pop_front();
        n_checked++;
        if (res_o.line_count !== want_r.line_count) begin
          $display("%0t: line_count expected %0d actual %0d", $time,
                   want_r.line_count, res_o.line_count);
          n_errors++;
        end
        if (res_o.scale_register !== want_r.scale_register) begin
          $display("%0t: scale_register expected 0x%03h actual 0x%03h", $time,
                   want_r.scale_register, res_o.scale_register);
          n_errors++;
        end
        if (res_o.ratio_num !== want_r.ratio_num) begin
          $display("%0t: ratio_num expected %0d actual %0d", $time,
                   want_r.ratio_num, res_o.ratio_num);
          n_errors++;
        end
        if (res_o.ratio_den !== want_r.ratio_den) begin
          $display("%0t: ratio_den expected %0d actual %0d", $time,
                   want_r.ratio_den, res_o.ratio_den);
          n_errors++;
        end
      end
    end
  end

  // Abort a hung run.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               outcome_q.size());
      $display("display_copy_vertical_scaler_lines_core test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Line-count requests at the height and register extremes and around the bump range.
  task automatic test_line_count_edges();
    issue_request(make_request(FuncLines, 0, 0, 0));          // zero register, zero height
    issue_request(make_request(FuncLines, MaxHeight, 1024, 0)); // zero register passes height
    issue_request(make_request(FuncLines, 0, 2047, 5));       // zero height
    issue_request(make_request(FuncLines, MaxHeight, 0, 1));  // smallest register, capped
    issue_request(make_request(FuncLines, MaxHeight, 7, 'h1FF));
    issue_request(make_request(FuncLines, 1, 0, 'h100));      // unit scale, single line
    issue_request(make_request(FuncLines, 129, 0, 'h81));     // odd part divides: bump
    issue_request(make_request(FuncLines, 3, 0, 'h81));       // odd part does not divide
    issue_request(make_request(FuncLines, 255, 0, 'hFF));     // top of bump range
    issue_request(make_request(FuncLines, 768, 0, 'hC0));     // bump up to the cap
    issue_request(make_request(FuncLines, 512, 0, 'h80));     // just below bump range
    issue_request(make_request(FuncLines, 1023, 0, 'h155));
    issue_request(make_request(FuncLines, 682, 1365, 'hAA));
  endtask

  // Scale searches: unit-scale paths, a walk down to a zero target, ordinary fits.
  task automatic test_scale_search_edges();
    issue_request(make_request(FuncSearch, 0, 500, 'h1FF));
    issue_request(make_request(FuncSearch, 700, 0, 0));
    issue_request(make_request(FuncSearch, 0, 0, 'h0AA));
    issue_request(make_request(FuncSearch, MaxHeight, 1024, 'h155));
    issue_request(make_request(FuncSearch, 480, 1024, 0));
    issue_request(make_request(FuncSearch, 1000, 100, 0));    // walks down to numerator zero
    issue_request(make_request(FuncSearch, 1, 1, 0));
    issue_request(make_request(FuncSearch, 5, 3, 0));
    issue_request(make_request(FuncSearch, 240, 480, 'h100));
    issue_request(make_request(FuncSearch, 576, 480, 0));
    issue_request(make_request(FuncSearch, MaxHeight, 1, 0));
  endtask

  // A destination no scale can reach: the upward walk runs to the target ceiling.
  task automatic test_unreachable_height();
    issue_request(make_request(FuncSearch, 1, 1024, 0));
  endtask

  // Random mix, weighted toward searches whose target lands near the wanted height.
  task automatic test_random_mix(input int idle_pct, input int n_items);
    int unsigned h;
    int unsigned d;
    int unsigned c;
    int unsigned pick;
    logic        f;
    sender_idle_pct = idle_pct;
    for (int i = 0; i < n_items; i++) begin
      pick = $urandom_range(99);
      d    = $urandom_range(0, MaxHeight);
      c    = $urandom_range(0, 511);
      if (pick < 30) begin
        f = FuncLines;
        h = ($urandom_range(9) == 0) ? (($urandom_range(1) == 0) ? 0 : MaxHeight)
                                     : $urandom_range(0, MaxHeight);
      end else if (pick < 45) begin
        // Height a multiple of the register's odd part, to hit the extra line.
        f = FuncLines;
        c = $urandom_range('h81, 'hFF);
        h = odd_part(c) * $urandom_range(1, MaxHeight / odd_part(c));
      end else if (pick < 80) begin
        // Well-formed search: destination above half the source height.
        f = FuncSearch;
        if ($urandom_range(4) != 0) begin
          h = $urandom_range(64, MaxHeight);
          d = $urandom_range(h / 2 + 1, MaxHeight);
        end else begin
          h = $urandom_range(5, 63);
          d = $urandom_range(h / 2 + 1, 300);
        end
      end else if (pick < 92) begin
        // Small destination, any source: short walk down, often to a wrapped register.
        f = FuncSearch;
        h = $urandom_range(5, MaxHeight);
        d = $urandom_range(1, 64);
      end else if (pick < 96) begin
        f = FuncSearch;
        h = $urandom_range(1, 4);
        d = $urandom_range(1, (h - 1) * ScaleOne + 1);
      end else begin
        f = FuncSearch;
        h = ($urandom_range(1) == 0) ? 0 : $urandom_range(0, MaxHeight);
        d = (h == 0) ? d : 0;
      end
      issue_request(make_request(f, h, d, c));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    start           <= 1'b0;
    req_i           <= '0;
    rst_ni          <= 1'b0;
    sender_idle_pct = 16;
    cycle_count     = 0;
    n_line_reqs     = 0;
    n_search_reqs   = 0;
    n_checked       = 0;
    n_errors        = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_line_count_edges();
    test_scale_search_edges();
    test_unreachable_height();
    test_random_mix(16, 90);
    test_random_mix(60, 90);
    test_random_mix(0, 90);

    // Release start, wait out every pending result, then watch for strays.
    start <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Ran %0d line-count and %0d scale-search requests in %0d cycles",
             n_line_reqs, n_search_reqs, cycle_count);
    $display("Compared %0d results, %0d field mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("display_copy_vertical_scaler_lines_core test passed");
    end else begin
      $display("display_copy_vertical_scaler_lines_core test failed");
    end
    $finish;
  end

endmodule
